@@ rtl/crc_framed_packet_parser_assert.svh @@
// Assertion macros shared by the frame parser RTL.
`ifndef CRC_FRAMED_PACKET_PARSER_ASSERT_SVH
`define CRC_FRAMED_PACKET_PARSER_ASSERT_SVH

// Same-cycle implication, checked out of reset.
`define CFPP_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked out of reset.
`define CFPP_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/cfpp_pkg.sv @@
// Types, codes and the CRC-32 byte update for the framed packet parser.
`default_nettype none

package cfpp_pkg;

    // Parser phases
    localparam logic [1:0] PH_HEADER = 2'd0;
    localparam logic [1:0] PH_BODY   = 2'd1;
    localparam logic [1:0] PH_CHECK  = 2'd2;
    localparam logic [1:0] PH_DONE   = 2'd3;

    // Result status codes
    localparam logic [1:0] ST_MORE  = 2'd0;
    localparam logic [1:0] ST_DONE  = 2'd1;
    localparam logic [1:0] ST_ERROR = 2'd2;

    // Error kinds
    localparam logic [1:0] ERR_NONE      = 2'd0;
    localparam logic [1:0] ERR_MAGIC     = 2'd1;
    localparam logic [1:0] ERR_TOO_LONG  = 2'd2;
    localparam logic [1:0] ERR_CRC       = 2'd3;

    // Request commands
    localparam logic CMD_DATA    = 1'b0;
    localparam logic CMD_RESTART = 1'b1;

    // Configuration register indexes
    localparam logic CFG_MAGIC = 1'b0;
    localparam logic CFG_LIMIT = 1'b1;

    localparam logic [15:0] MAGIC_RESET = 16'h4547;
    localparam logic [15:0] LIMIT_RESET = 16'd4096;

    localparam logic [2:0] HDR_LAST = 3'd7;
    localparam logic [1:0] CHK_LAST = 2'd3;

    localparam logic [31:0] CRC_INIT = 32'hFFFF_FFFF;
    localparam logic [31:0] CRC_POLY = 32'hEDB8_8320;

    typedef struct packed {
        logic       cmd;
        logic [7:0] rx_byte;
    } in_t;

    typedef struct packed {
        logic        consumed;
        logic [1:0]  status;
        logic [1:0]  error_kind;
        logic [7:0]  payload_byte;
        logic        payload_strobe;
        logic [7:0]  frame_version;
        logic [7:0]  frame_flags;
        logic [15:0] message_type;
        logic [15:0] body_length;
        logic [31:0] frame_check;
        logic [31:0] good_frames;
        logic [31:0] bad_frames;
    } out_t;

    // Reflected CRC-32, one byte, bit-serial form unrolled over eight steps.
    function automatic logic [31:0] crc32_byte(input logic [31:0] crc_in,
                                               input logic [7:0]  data);
        logic [31:0] c;
        c = crc_in ^ {24'd0, data};
        for (int i = 0; i < 8; i++) begin
            c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        end
        return c;
    endfunction

endpackage

`default_nettype wire

@@ rtl/crc_framed_packet_parser.sv @@
// Length-prefixed frame parser with running CRC-32 check, one byte per request.
//
//  Channel  Ports                        Dir  Moves
//  -------  ---------------------------  ---  -------------------------------------
//  input    s_valid s_ready s_data       in   one byte or a restart per request
//  result   m_valid m_ready m_data       out  one result per input request
//  config   cfg_we cfg_addr cfg_wdata    in   magic word / payload limit writes
//
// Throughput is one request per cycle unless the result stalls. The path per
// request is the byte-wide CRC-32 update (eight shift/xor steps) plus the
// header and length compares, all between the parser state registers and the
// result register. aresetn is synchronous, active low; no clearing pass follows
// reset. s_ready stays high while the result register is empty or being
// drained, so a stalled result holds only the input side.
`default_nettype none

`include "crc_framed_packet_parser_assert.svh"

module crc_framed_packet_parser (
    input  wire logic            aclk,
    input  wire logic            aresetn,
    // input channel
    input  wire logic            s_valid,
    output logic                 s_ready,
    input  wire cfpp_pkg::in_t   s_data,
    // result channel
    output logic                 m_valid,
    input  wire logic            m_ready,
    output cfpp_pkg::out_t       m_data,
    // configuration writes
    input  wire logic            cfg_we,
    input  wire logic            cfg_addr,
    input  wire logic [15:0]     cfg_wdata
);

    import cfpp_pkg::*;

    // ---------------- configuration ----------------
    logic [15:0] magic_word_reg;
    logic [15:0] payload_limit_reg;

    // ---------------- parser state ----------------
    logic [1:0]  phase_reg,     phase_next;
    logic [2:0]  hdr_idx_reg,   hdr_idx_next;
    logic [7:0]  hdr_reg  [8];
    logic [7:0]  hdr_next [8];
    logic [15:0] body_cnt_reg,  body_cnt_next;
    logic [15:0] body_exp_reg,  body_exp_next;
    logic [1:0]  chk_idx_reg,   chk_idx_next;
    logic [31:0] chk_reg,       chk_next;
    logic [31:0] crc_reg,       crc_next;
    logic [31:0] good_reg,      good_next;
    logic [31:0] bad_reg,       bad_next;

    // ---------------- result register ----------------
    logic        m_valid_reg;
    out_t        m_data_reg;
    out_t        res;

    logic        s_fire;
    logic        clear;
    logic [1:0]  kind;
    logic [15:0] hdr_magic;
    logic [15:0] hdr_len;

    assign s_ready = !m_valid_reg || m_ready;
    assign s_fire  = s_valid && s_ready;
    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    // Header fields as seen at the final header byte: byte 7 is the current one.
    assign hdr_magic = {hdr_reg[1], hdr_reg[0]};
    assign hdr_len   = {s_data.rx_byte, hdr_reg[6]};

    // Next state and result for the request on the input port.
    always_comb begin
        phase_next    = phase_reg;
        hdr_idx_next  = hdr_idx_reg;
        hdr_next      = hdr_reg;
        body_cnt_next = body_cnt_reg;
        body_exp_next = body_exp_reg;
        chk_idx_next  = chk_idx_reg;
        chk_next      = chk_reg;
        crc_next      = crc_reg;
        good_next     = good_reg;
        bad_next      = bad_reg;
        clear         = 1'b0;
        kind          = ERR_NONE;
        res           = '0;

        if (s_data.cmd == CMD_RESTART) begin
            clear = 1'b1;
        end else begin
            case (phase_reg)
                PH_HEADER: begin
                    res.consumed          = 1'b1;
                    hdr_next[hdr_idx_reg] = s_data.rx_byte;
                    hdr_idx_next          = hdr_idx_reg + 3'd1;
                    crc_next              = crc32_byte(crc_reg, s_data.rx_byte);
                    if (hdr_idx_reg == HDR_LAST) begin
                        if (hdr_magic != magic_word_reg) begin
                            kind = ERR_MAGIC;
                        end else if (hdr_len > payload_limit_reg) begin
                            kind = ERR_TOO_LONG;
                        end else begin
                            body_exp_next = hdr_len;
                            body_cnt_next = '0;
                            chk_idx_next  = '0;
                            phase_next    = (hdr_len == 16'd0) ? PH_CHECK : PH_BODY;
                        end
                    end
                end
                PH_BODY: begin
                    res.consumed       = 1'b1;
                    res.payload_byte   = s_data.rx_byte;
                    res.payload_strobe = 1'b1;
                    crc_next           = crc32_byte(crc_reg, s_data.rx_byte);
                    body_cnt_next      = body_cnt_reg + 16'd1;
                    if (body_cnt_next >= body_exp_reg) begin
                        chk_idx_next = '0;
                        phase_next   = PH_CHECK;
                    end
                end
                PH_CHECK: begin
                    res.consumed = 1'b1;
                    chk_next[{chk_idx_reg, 3'b000} +: 8] = s_data.rx_byte;
                    chk_idx_next = chk_idx_reg + 2'd1;
                    if (chk_idx_reg == CHK_LAST) begin
                        if (~crc_reg != chk_next) begin
                            kind = ERR_CRC;
                        end else begin
                            good_next  = good_reg + 32'd1;
                            phase_next = PH_DONE;
                        end
                    end
                end
                default: begin
                    // Frame complete: bytes are reported as not consumed until restart.
                end
            endcase
        end

        res.error_kind = kind;
        if (kind != ERR_NONE) begin
            bad_next   = bad_reg + 32'd1;
            clear      = 1'b1;
            res.status = ST_ERROR;
        end else if (!clear && phase_next == PH_DONE) begin
            res.status      = ST_DONE;
            res.frame_check = chk_next;
        end else begin
            res.status = ST_MORE;
        end

        if (clear) begin
            phase_next    = PH_HEADER;
            hdr_idx_next  = '0;
            body_cnt_next = '0;
            body_exp_next = '0;
            chk_idx_next  = '0;
            crc_next      = CRC_INIT;
        end

        // Header fields read as zero while back in the header phase.
        if (phase_next != PH_HEADER) begin
            res.frame_version = hdr_next[2];
            res.frame_flags   = hdr_next[3];
            res.message_type  = {hdr_next[5], hdr_next[4]};
            res.body_length   = {hdr_next[7], hdr_next[6]};
        end
        res.good_frames = good_next;
        res.bad_frames  = bad_next;
    end

    // Control state and configuration.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            magic_word_reg    <= MAGIC_RESET;
            payload_limit_reg <= LIMIT_RESET;
            phase_reg         <= PH_HEADER;
            hdr_idx_reg       <= '0;
            body_cnt_reg      <= '0;
            body_exp_reg      <= '0;
            chk_idx_reg       <= '0;
            crc_reg           <= CRC_INIT;
            good_reg          <= '0;
            bad_reg           <= '0;
            m_valid_reg       <= 1'b0;
        end else begin
            if (cfg_we) begin
                case (cfg_addr)
                    CFG_MAGIC: magic_word_reg    <= cfg_wdata;
                    CFG_LIMIT: payload_limit_reg <= cfg_wdata;
                    default:   ;
                endcase
            end
            if (s_fire) begin
                phase_reg    <= phase_next;
                hdr_idx_reg  <= hdr_idx_next;
                body_cnt_reg <= body_cnt_next;
                body_exp_reg <= body_exp_next;
                chk_idx_reg  <= chk_idx_next;
                crc_reg      <= crc_next;
                good_reg     <= good_next;
                bad_reg      <= bad_next;
                m_valid_reg  <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg  <= 1'b0;
            end
        end
    end

    // Payload registers: header bytes, received CRC and the result word.
    always_ff @(posedge aclk) begin
        if (s_fire) begin
            hdr_reg    <= hdr_next;
            chk_reg    <= chk_next;
            m_data_reg <= res;
        end
    end

    // ---------------- assertions ----------------
    `CFPP_ASSERT_NEXT(a_error_clears, s_fire && res.status == ST_ERROR,
        phase_reg == PH_HEADER && hdr_idx_reg == 3'd0 && crc_reg == CRC_INIT,
        "error did not return the parser to the header phase")
    `CFPP_ASSERT_NOW(a_done_matches_phase, m_valid_reg && m_data_reg.status == ST_DONE,
        phase_reg == PH_DONE, "complete status without the complete phase")
    `CFPP_ASSERT_NEXT(a_bad_count_only_on_error, s_fire && res.status != ST_ERROR,
        $stable(bad_reg), "reject counter moved without an error")
    `CFPP_ASSERT_NOW(a_header_fields_zero, m_valid_reg && phase_reg == PH_HEADER,
        m_data_reg.body_length == 16'd0 && m_data_reg.message_type == 16'd0,
        "header fields shown while in the header phase")

endmodule

`default_nettype wire
